// ----- src/bdw_pkg.sv -----
// ----------------------------------------------------------------------------
// bdw_pkg: shared types and constants
// Field types, the blank code, the divide-by-ten constants that the digit
// stages use and the display bound that the clamp uses.
// ----------------------------------------------------------------------------
package bdw_pkg;

    localparam int VALUE_W   = 27;
    localparam int CODE_W    = 4;
    localparam int MAX_DIGITS = 8;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CODE_W-1:0]  t_code;

    localparam t_code BLANK_CODE = 4'hF;

    // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every x below 2^32
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = VALUE_W + 32;

    // Largest number that n digits can show: 10^n - 1
    function automatic t_value max_shown(input int n);
        longint acc;
        acc = 1;
        for (int k = 0; k < n; k++) begin
            acc = acc * 10;
        end
        acc = acc - 1;
        return acc[VALUE_W-1:0];
    endfunction

endpackage

// ----- src/bdw_clamp.sv -----
// ----------------------------------------------------------------------------
// bdw_clamp: entry stage
// Registers the incoming request and clamps it to the largest number the
// display can show.
// ----------------------------------------------------------------------------
module bdw_clamp #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  bdw_pkg::t_value i_value,
    output logic            o_rdy,
    output logic            o_vld,
    output bdw_pkg::t_value o_rest,
    input  logic            i_rdy
);
    import bdw_pkg::*;

    localparam t_value LIMIT = max_shown(DIGIT_COUNT);

    logic   r_vld;
    t_value r_rest;
    t_value n_rest;

    assign o_rdy  = !r_vld || i_rdy;
    assign n_rest = (i_value > LIMIT) ? LIMIT : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_rest <= n_rest;
        end
    end

    assign o_vld  = r_vld;
    assign o_rest = r_rest;

endmodule

// ----- src/bdw_div_stage.sv -----
// ----------------------------------------------------------------------------
// bdw_div_stage: one digit of the conversion
// Divides the remaining value by ten, files the remainder as the digit of
// its position (or blank above the leading digit) and passes the quotient on.
// ----------------------------------------------------------------------------
module bdw_div_stage #(
    parameter int DIGIT_COUNT = 8,
    parameter int IDX         = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  bdw_pkg::t_value                     i_rest,
    input  bdw_pkg::t_code [DIGIT_COUNT-1:0]    i_codes,
    output logic                                o_rdy,
    output logic                                o_vld,
    output bdw_pkg::t_value                     o_rest,
    output bdw_pkg::t_code [DIGIT_COUNT-1:0]    o_codes,
    input  logic                                i_rdy
);
    import bdw_pkg::*;

    logic                      r_vld;
    t_value                    r_rest;
    t_code [DIGIT_COUNT-1:0]   r_codes;

    logic [PROD_W-1:0]         prod;
    t_value                    quot;
    t_value                    quot_x10;
    t_value                    rem;
    t_code [DIGIT_COUNT-1:0]   n_codes;

    always_comb begin
        prod     = PROD_W'(i_rest) * PROD_W'(RECIP_TEN);
        quot     = t_value'(prod[PROD_W-1:RECIP_SHIFT]);
        quot_x10 = (quot << 3) + (quot << 1);
        rem      = i_rest - quot_x10;
        n_codes  = i_codes;
        // blank every position above the leading digit
        if (IDX == 0 || i_rest != '0) begin
            n_codes[IDX] = rem[CODE_W-1:0];
        end else begin
            n_codes[IDX] = BLANK_CODE;
        end
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_rest  <= quot;
            r_codes <= n_codes;
        end
    end

    assign o_vld   = r_vld;
    assign o_rest  = r_rest;
    assign o_codes = r_codes;

endmodule

// ----- src/bdw_serializer.sv -----
// ----------------------------------------------------------------------------
// bdw_serializer: write sequencer
// Holds one converted number and issues its digit-register writes, one a
// cycle, lowest position first.
// ----------------------------------------------------------------------------
module bdw_serializer #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  bdw_pkg::t_code [DIGIT_COUNT-1:0]    i_codes,
    output logic                                o_rdy,
    output logic                                o_strobe,
    output bdw_pkg::t_code                      o_digit_position,
    output bdw_pkg::t_code                      o_digit_code,
    output logic                                o_last_of_run
);
    import bdw_pkg::*;

    localparam t_code LAST_POS = CODE_W'(DIGIT_COUNT);

    logic                      r_vld;
    t_code                     r_pos;
    t_code [DIGIT_COUNT-1:0]   r_codes;
    t_code [DIGIT_COUNT-1:0]   n_codes;
    logic                      last;

    assign last  = (r_pos == LAST_POS);
    assign o_rdy = !r_vld || last;

    always_comb begin
        n_codes = r_codes;
        for (int k = 0; k < DIGIT_COUNT - 1; k++) begin
            n_codes[k] = r_codes[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_pos <= 4'd1;
        end else if (o_rdy) begin
            r_vld <= i_vld;
            r_pos <= 4'd1;
        end else begin
            // advance to the next position
            r_pos <= r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            if (i_vld) begin
                r_codes <= i_codes;
            end
        end else begin
            r_codes <= n_codes;
        end
    end

    assign o_strobe         = r_vld;
    assign o_digit_position = r_pos;
    assign o_digit_code     = r_codes[0];
    assign o_last_of_run    = r_vld && last;

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !last) |=> (r_vld && r_pos == $past(r_pos) + 4'd1))
        else $error("write run broken before its last position");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_pos >= 4'd1 && r_pos <= LAST_POS))
        else $error("digit position out of range");

    a_first_not_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_pos == 4'd1) |-> (o_digit_code != BLANK_CODE))
        else $error("lowest digit written as blank");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_code <= 4'd9 || o_digit_code == BLANK_CODE))
        else $error("digit code neither decimal nor blank");

endmodule

// ----- src/binary_to_digit_display_writes.sv -----
// ----------------------------------------------------------------------------
// binary_to_digit_display_writes: binary number to digit-register writes
// Converts an unsigned number to decimal and issues one register write per
// digit position for a seven-segment display driver.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive i_value and raise start; the request is taken at the
//   rising edge where start is high and busy is low. Values above
//   10^DIGIT_COUNT - 1 are clamped to that bound.
//   Results: DIGIT_COUNT writes on consecutive cycles, each marked by
//   o_strobe for one cycle, position 1 (least significant) first. Positions
//   above the leading digit carry code 15 (blank); zero shows one 0.
//   o_last_of_run marks the final write of a request.
//   Path: the clamp register loads at the accepting edge, then one
//   divide-by-ten stage per digit, then the load into the write
//   sequencer; a stage holds its request while the next one is full.
//   Throughput: set by the write sequencer issuing one write a cycle; it
//   takes the next request only with its last write, and the stage chain
//   holds further requests meanwhile and raises busy once it is full.
//   Reset: synchronous, active low; clears all valid bits, so any request
//   in flight is dropped. The receiver cannot stall: every strobe is a
//   delivered write.
// ----------------------------------------------------------------------------
module binary_to_digit_display_writes #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bdw_pkg::t_value i_value,
    output logic            busy,
    output logic            o_strobe,
    output bdw_pkg::t_code  o_digit_position,
    output bdw_pkg::t_code  o_digit_code,
    output logic            o_last_of_run
);
    import bdw_pkg::*;

    logic                      clamp_rdy;
    logic [DIGIT_COUNT:0]      stg_vld;
    logic [DIGIT_COUNT:0]      stg_rdy;
    t_value                    stg_rest  [DIGIT_COUNT+1];
    t_code [DIGIT_COUNT-1:0]   stg_codes [DIGIT_COUNT+1];

    assign busy         = !clamp_rdy;
    assign stg_codes[0] = '0;

    bdw_clamp #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_value (i_value),
        .o_rdy   (clamp_rdy),
        .o_vld   (stg_vld[0]),
        .o_rest  (stg_rest[0]),
        .i_rdy   (stg_rdy[0])
    );

    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
        bdw_div_stage #(
            .DIGIT_COUNT (DIGIT_COUNT),
            .IDX         (g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (stg_vld[g]),
            .i_rest  (stg_rest[g]),
            .i_codes (stg_codes[g]),
            .o_rdy   (stg_rdy[g]),
            .o_vld   (stg_vld[g+1]),
            .o_rest  (stg_rest[g+1]),
            .o_codes (stg_codes[g+1]),
            .i_rdy   (stg_rdy[g+1])
        );
    end

    bdw_serializer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_ser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (stg_vld[DIGIT_COUNT]),
        .i_codes          (stg_codes[DIGIT_COUNT]),
        .o_rdy            (stg_rdy[DIGIT_COUNT]),
        .o_strobe         (o_strobe),
        .o_digit_position (o_digit_position),
        .o_digit_code     (o_digit_code),
        .o_last_of_run    (o_last_of_run)
    );

    a_busy_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (stg_vld[0] && !stg_rdy[0]))
        else $error("busy raised while the entry stage can move");

    a_last_frees_ser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_run |-> stg_rdy[DIGIT_COUNT])
        else $error("sequencer not ready on the last write of a run");

    a_strobe_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last_of_run && !stg_vld[DIGIT_COUNT]) |=> !o_strobe)
        else $error("write issued with no request loaded");

endmodule
